/* hw/rtl/cursor_linked_list_engine_assert.svh */
// Assertion macros for the list engine.
`ifndef CURSOR_LINKED_LIST_ENGINE_ASSERT_SVH
`define CURSOR_LINKED_LIST_ENGINE_ASSERT_SVH
`define CLL_ASSERT_IMP(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (rst) \
  (a) |-> (c)) else $error("assertion failed");
`define CLL_ASSERT_NXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (rst) \
  (a) |=> (c)) else $error("assertion failed");
`endif

/* hw/rtl/cll_pkg.sv */
package cll_pkg;
  typedef enum logic [3:0] {
    K_INS_AFTER = 4'd0, K_INS_BEFORE = 4'd1, K_DELETE = 4'd2, K_FIRST = 4'd3,
    K_LAST = 4'd4, K_NEXT = 4'd5, K_POSITION = 4'd6, K_READ = 4'd7,
    K_COUNT = 4'd8, K_CLEAR = 4'd9
  } kind_t;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_NOCUR = 2'd3;
  typedef struct packed {
    logic [3:0] kind;
    logic signed [31:0] value;
    logic [4:0] position;
  } in_item_t;
  typedef struct packed {
    logic signed [31:0] read_value;
    logic [4:0] match_count;
    logic [4:0] list_length;
    logic at_end;
    logic [1:0] status;
  } out_item_t;
  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_WALK, S_FETCH, S_DONE} state_t;
  typedef struct packed {
    logic load;
    logic exec;
    logic step;
    logic fetch;
  } cmd_t;
  typedef struct packed {
    logic walk;
    logic walk_done;
  } sts_t;
endpackage

/* hw/rtl/cursor_linked_list_engine.sv */
// Linked list engine with one cursor, one result per item.
// Each accepted item passes through the exec and fetch states, and the result
// strobe is registered from fetch; position and count first walk the list one
// node per cycle. A new item is taken only once the last one is done (busy is
// low); results cannot be stalled.
// Synchronous reset empties the list and frees every node.
module cursor_linked_list_engine #(
  parameter int POOL_DEPTH = 16,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cll_pkg::in_item_t in_item,
  output logic busy,
  output logic strobe,
  output cll_pkg::out_item_t out_item
);
  import cll_pkg::*;
  cmd_t cmd;
  sts_t sts;
  cll_ctrl u_ctrl (.clk, .rst, .start, .sts, .cmd, .busy);
  cll_dp #(.DEPTH(POOL_DEPTH), .EW(ELEMENT_WIDTH)) u_dp (
    .clk, .rst, .cmd, .in_item, .sts, .out_item, .strobe);
endmodule

/* hw/rtl/cll_ctrl.sv */
module cll_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cll_pkg::sts_t sts,
  output cll_pkg::cmd_t cmd,
  output logic busy
);
  import cll_pkg::*;
  state_t state, state_next;
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_EXEC;
      S_EXEC: state_next = sts.walk ? S_WALK : S_FETCH;
      S_WALK: if (sts.walk_done) state_next = S_FETCH;
      S_FETCH: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
  always_comb begin
    cmd = '0;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: cmd.load = start;
      S_EXEC: cmd.exec = 1'b1;
      S_WALK: cmd.step = 1'b1;
      S_FETCH: cmd.fetch = 1'b1;
      default: ;
    endcase
  end
endmodule

/* hw/rtl/cll_dp.sv */
module cll_dp #(
  parameter int DEPTH = 16,
  parameter int EW = 32
) (
  input  logic clk,
  input  logic rst,
  input  cll_pkg::cmd_t cmd,
  input  cll_pkg::in_item_t in_item,
  output cll_pkg::sts_t sts,
  output cll_pkg::out_item_t out_item,
  output logic strobe
);
  import cll_pkg::*;
  localparam int IW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IW-1:0] NIL = IW'(DEPTH);

  logic [EW-1:0] vals [DEPTH];
  logic [IW-1:0] nxt [DEPTH];
  logic [IW-1:0] prv [DEPTH];
  logic [DEPTH-1:0] free_map;
  logic [IW-1:0] head, tail, cur, cnt;
  logic [IW-1:0] walk_p, steps;
  logic [4:0] pos_left;
  logic [IW-1:0] hit_cnt;
  logic [1:0] status;
  in_item_t it;
  logic walking;
  logic [EW-1:0] rd;

  wire cur_ok = cur < NIL;
  wire [EW-1:0] v_el = EW'(it.value);
  logic [IW-1:0] fidx;
  logic f_ok;
  always_comb begin
    fidx = NIL;
    f_ok = 1'b0;
    for (int i = DEPTH - 1; i >= 0; i--)
      if (free_map[i]) begin
        fidx = IW'(i);
        f_ok = 1'b1;
      end
  end
  wire [AW-1:0] ca = cur[AW-1:0];
  wire [AW-1:0] fa = fidx[AW-1:0];
  wire [AW-1:0] wa = walk_p[AW-1:0];
  wire [IW-1:0] c_nxt = nxt[ca];
  wire [IW-1:0] c_prv = prv[ca];
  wire walk_end = (walk_p >= NIL) || (it.kind == K_COUNT ? steps >= NIL : pos_left <= 5'd1);

  assign sts.walk = (it.kind == K_POSITION) || (it.kind == K_COUNT);
  assign sts.walk_done = walk_end;

  always_ff @(posedge clk) begin
    if (cmd.load) it <= in_item;
    if (cmd.fetch) rd <= cur_ok ? vals[ca] : '0;
    if (cmd.exec && (it.kind == K_INS_AFTER || it.kind == K_INS_BEFORE)
        && !(cnt != '0 && !cur_ok) && f_ok) begin
      vals[fa] <= v_el;
      if (cnt == '0) begin
        nxt[fa] <= NIL; prv[fa] <= NIL;
      end else if (it.kind == K_INS_AFTER) begin
        prv[fa] <= cur; nxt[fa] <= c_nxt; nxt[ca] <= fidx;
        if (c_nxt < NIL) prv[c_nxt[AW-1:0]] <= fidx;
      end else begin
        nxt[fa] <= cur; prv[fa] <= c_prv; prv[ca] <= fidx;
        if (c_prv < NIL) nxt[c_prv[AW-1:0]] <= fidx;
      end
    end
    if (cmd.exec && it.kind == K_DELETE && cnt != '0 && cur_ok) begin
      if (c_prv < NIL) nxt[c_prv[AW-1:0]] <= c_nxt;
      if (c_nxt < NIL) prv[c_nxt[AW-1:0]] <= c_prv;
    end
    if (cmd.step) begin
      if (!walk_end) begin
        if (it.kind == K_COUNT && vals[wa] == v_el) hit_cnt <= hit_cnt + 1'b1;
        walk_p <= nxt[wa];
        steps <= steps + 1'b1;
        pos_left <= pos_left - 1'b1;
      end
    end
    if (cmd.exec) begin
      walk_p <= head; steps <= '0; pos_left <= it.position; hit_cnt <= '0;
    end
    if (rst) begin
      free_map <= '1; head <= NIL; tail <= NIL; cur <= NIL; cnt <= '0;
      status <= ST_OK; strobe <= 1'b0; walking <= 1'b0;
    end else begin
      strobe <= cmd.fetch;
      if (cmd.exec) walking <= sts.walk;
      if (cmd.step && walk_end) begin
        walking <= 1'b0;
        cur <= (it.kind == K_COUNT) ? NIL : walk_p;
      end
      if (cmd.exec) begin
        status <= ST_OK;
        case (it.kind)
          K_INS_AFTER, K_INS_BEFORE: begin
            if (cnt != '0 && !cur_ok) status <= ST_NOCUR;
            else if (!f_ok) status <= ST_FULL;
            else begin
              free_map[fa] <= 1'b0;
              if (cnt == '0) begin
                head <= fidx; tail <= fidx;
              end else if (it.kind == K_INS_AFTER) begin
                if (c_nxt >= NIL) tail <= fidx;
              end else if (c_prv >= NIL) head <= fidx;
              cur <= fidx; cnt <= cnt + 1'b1;
            end
          end
          K_DELETE: begin
            if (cnt == '0) status <= ST_EMPTY;
            else if (!cur_ok) status <= ST_NOCUR;
            else begin
              free_map[ca] <= 1'b1;
              cnt <= cnt - 1'b1;
              if (cnt == IW'(1)) begin
                head <= NIL; tail <= NIL; cur <= NIL;
              end else begin
                if (c_prv >= NIL) head <= c_nxt;
                if (c_nxt >= NIL) tail <= c_prv;
                cur <= (c_prv >= NIL) ? c_nxt : c_prv;
              end
            end
          end
          K_FIRST: cur <= head;
          K_LAST: cur <= tail;
          K_NEXT: if (cur_ok) cur <= c_nxt; else status <= ST_NOCUR;
          K_READ: if (!cur_ok) status <= ST_NOCUR;
          K_CLEAR: begin
            free_map <= '1; head <= NIL; tail <= NIL; cur <= NIL; cnt <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  function automatic logic [4:0] sat5(logic [IW-1:0] n);
    return (n > IW'(31)) ? 5'd31 : 5'(n);
  endfunction

  always_comb begin
    out_item.read_value = 32'(signed'(rd));
    out_item.match_count = (it.kind == K_COUNT) ? sat5(hit_cnt) : 5'd0;
    out_item.list_length = sat5(cnt);
    out_item.at_end = !cur_ok;
    out_item.status = status;
  end

  `include "cursor_linked_list_engine_assert.svh"
  `CLL_ASSERT_IMP(a_cnt_le_depth, 1'b1, cnt <= NIL)
  `CLL_ASSERT_IMP(a_empty_nil, cnt == '0, head == NIL && tail == NIL)
  `CLL_ASSERT_NXT(a_strobe_after_fetch, cmd.fetch, strobe)
  `CLL_ASSERT_IMP(a_step_walking, cmd.step, walking)
endmodule

/* dv/cursor_linked_list_engine_test.sv */
module cursor_linked_list_engine_test;
  import cll_pkg::*;

  localparam int DEPTH = 16;
  localparam int NIL = DEPTH;
  localparam int CYCLE_LIMIT = 400000;

  class list_scoreboard;
    logic [31:0] vals[DEPTH];
    int nxt[DEPTH];
    int prv[DEPTH];
    bit free_node[DEPTH];
    int head, tail, cur, count;
    out_item_t pending[$];
    int mismatches;
    int checked;

    function new();
      mismatches = 0;
      checked = 0;
      clear_list();
    endfunction

    function void clear_list();
      for (int i = 0; i < DEPTH; i++) begin
        nxt[i] = NIL;
        prv[i] = NIL;
        free_node[i] = 1;
        vals[i] = '0;
      end
      head = NIL;
      tail = NIL;
      cur = NIL;
      count = 0;
    endfunction

    function logic [1:0] insert_elem(logic [31:0] v, bit after);
      int n, o;
      if (count != 0 && cur == NIL) return ST_NOCUR;
      n = NIL;
      for (int i = DEPTH - 1; i >= 0; i--) if (free_node[i]) n = i;
      if (n == NIL) return ST_FULL;
      free_node[n] = 0;
      vals[n] = v;
      nxt[n] = NIL;
      prv[n] = NIL;
      if (count == 0) begin
        head = n;
        tail = n;
      end else if (after) begin
        o = nxt[cur];
        prv[n] = cur;
        nxt[n] = o;
        nxt[cur] = n;
        if (o != NIL) prv[o] = n;
        else tail = n;
      end else begin
        o = prv[cur];
        nxt[n] = cur;
        prv[n] = o;
        prv[cur] = n;
        if (o != NIL) nxt[o] = n;
        else head = n;
      end
      cur = n;
      count++;
      return ST_OK;
    endfunction

    function logic [1:0] delete_elem();
      int c, p, s;
      if (count == 0) return ST_EMPTY;
      c = cur;
      if (c == NIL) return ST_NOCUR;
      p = prv[c];
      s = nxt[c];
      if (p != NIL) nxt[p] = s;
      else head = s;
      if (s != NIL) prv[s] = p;
      else tail = p;
      cur = (c == head || p == NIL) ? head : p;
      nxt[c] = NIL;
      prv[c] = NIL;
      free_node[c] = 1;
      count--;
      if (count == 0) begin
        head = NIL;
        tail = NIL;
        cur = NIL;
      end
      return ST_OK;
    endfunction

    function void note_item(in_item_t it);
      out_item_t r;
      int p, m, i;
      logic [1:0] st;
      st = ST_OK;
      m = 0;
      case (it.kind)
        K_INS_AFTER: st = insert_elem(it.value, 1);
        K_INS_BEFORE: st = insert_elem(it.value, 0);
        K_DELETE: st = delete_elem();
        K_FIRST: cur = head;
        K_LAST: cur = tail;
        K_NEXT: begin
          if (cur != NIL) cur = nxt[cur];
          else st = ST_NOCUR;
        end
        K_POSITION: begin
          p = head;
          for (i = 1; i < it.position && p != NIL; i++) p = nxt[p];
          cur = p;
        end
        K_READ: if (cur == NIL) st = ST_NOCUR;
        K_COUNT: begin
          p = head;
          for (i = 0; i < DEPTH && p != NIL; i++) begin
            if (vals[p] == it.value) m++;
            p = nxt[p];
          end
          cur = NIL;
        end
        K_CLEAR: clear_list();
        default: ;
      endcase
      r.read_value = (cur != NIL) ? vals[cur] : '0;
      r.match_count = (m > 31) ? 5'd31 : m[4:0];
      r.list_length = (count > 31) ? 5'd31 : count[4:0];
      r.at_end = (cur == NIL);
      r.status = st;
      pending.push_back(r);
    endfunction

    function bit check_result(out_item_t got);
      out_item_t exp;
      bit bad;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return 0;
      end
      exp = pending.pop_front();
      checked++;
      bad = exp.read_value !== got.read_value || exp.match_count !== got.match_count ||
            exp.list_length !== got.list_length || exp.at_end !== got.at_end ||
            exp.status !== got.status;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %h/%0d/%0d/%b/%0d got %h/%0d/%0d/%b/%0d",
                   exp.read_value, exp.match_count, exp.list_length, exp.at_end, exp.status,
                   got.read_value, got.match_count, got.list_length, got.at_end, got.status);
      end
      return !bad;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  in_item_t in_item;
  logic busy;
  logic strobe;
  out_item_t out_item;
  list_scoreboard sb;
  int cycles;
  int sent;
  bit no_idle;
  logic [31:0] seen_vals[$];
  int kind_hits[16];

  cursor_linked_list_engine dut (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item),
    .busy(busy), .strobe(strobe), .out_item(out_item)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (!rst && strobe) void'(sb.check_result(out_item));
  end

  task automatic send_item(logic [3:0] k, logic [31:0] v, logic [4:0] p);
    in_item_t it;
    it.kind = k;
    it.value = v;
    it.position = p;
    while (!no_idle && $urandom_range(99) < 36) @(posedge clk);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(it);
    kind_hits[k]++;
    sent++;
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    if (seen_vals.size() != 0 && $urandom_range(2) == 0)
      return seen_vals[$urandom_range(seen_vals.size() - 1)];
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_item();
    int r;
    logic [31:0] v;
    v = pick_value();
    r = $urandom_range(99);
    if (seen_vals.size() > 40) seen_vals.delete(0);
    if (r < 30) begin
      seen_vals.push_back(v);
      send_item($urandom_range(1) ? K_INS_AFTER : K_INS_BEFORE, v, 5'($urandom));
    end else if (r < 42) send_item(K_DELETE, v, 5'($urandom));
    else if (r < 48) send_item(K_FIRST, v, 5'($urandom));
    else if (r < 54) send_item(K_LAST, v, 5'($urandom));
    else if (r < 64) send_item(K_NEXT, v, 5'($urandom));
    else if (r < 76)
      send_item(K_POSITION, v, 5'($urandom_range(1) ? $urandom_range(18) : $urandom));
    else if (r < 84) send_item(K_READ, v, 5'($urandom));
    else if (r < 94) send_item(K_COUNT, v, 5'($urandom));
    else if (r < 96) send_item(K_CLEAR, v, 5'($urandom));
    else send_item(4'($urandom_range(15, 10)), v, 5'($urandom));
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    cycles = 0;
    sent = 0;
    no_idle = 0;
    rst = 1'b1;
    start = 1'b0;
    in_item = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(K_DELETE, 0, 0);
    send_item(K_FIRST, 0, 0);
    send_item(K_LAST, 0, 0);
    send_item(K_NEXT, 0, 0);
    send_item(K_READ, 0, 0);
    send_item(K_INS_AFTER, 32'h8000_0000, 0);
    send_item(K_INS_BEFORE, 32'h7fff_ffff, 0);
    send_item(K_INS_AFTER, 32'hffff_ffff, 0);
    send_item(K_POSITION, 0, 0);
    send_item(K_POSITION, 0, 1);
    send_item(K_POSITION, 0, 31);
    send_item(K_INS_AFTER, 5, 0);
    send_item(K_DELETE, 0, 0);
    send_item(K_NEXT, 0, 0);
    send_item(K_READ, 0, 0);
    for (int i = 0; i < 15; i++) send_item(K_INS_BEFORE, 32'h1, 5'd0);
    send_item(K_LAST, 0, 0);
    send_item(K_COUNT, 32'h1, 0);
    send_item(K_COUNT, 32'h8000_0000, 0);
    send_item(K_FIRST, 0, 0);
    send_item(K_DELETE, 0, 0);
    send_item(K_LAST, 0, 0);
    send_item(K_DELETE, 0, 0);
    send_item(4'd15, 0, 0);
    send_item(K_CLEAR, 0, 0);
    wait_drained();

    for (int n = 0; n < 400; n++) begin
      no_idle = (n >= 150 && n < 230);
      if (n == 300) begin
        wait_drained();
        repeat (30) @(posedge clk);
      end
      random_item();
    end
    wait_drained();
    repeat (40) @(posedge clk);

    $display("run covered %0d items, %0d results checked, inserts %0d, walks %0d, counts %0d",
             sent, sb.checked, kind_hits[K_INS_AFTER] + kind_hits[K_INS_BEFORE],
             kind_hits[K_POSITION], kind_hits[K_COUNT]);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d left over", sb.mismatches, sb.pending.size());
      $display("tb: failure");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/cll_pkg.sv
hw/rtl/cll_ctrl.sv
hw/rtl/cll_dp.sv
hw/rtl/cursor_linked_list_engine.sv
dv/cursor_linked_list_engine_test.sv
